[hdl/opl_pkg.sv]
`default_nettype none

package opl_pkg;

  // fixed field widths of the request and result channels
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned PID_W    = 8;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned STATUS_W = 2;

  // request kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_POP    = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_e_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_e_t;

  // operation broadcast to every cell of the row
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2
  } cell_op_e_t;

  // per-cell control: the operation and where the cell sits relative to the target
  typedef struct packed {
    cell_op_e_t op;
    logic       at;     // cell index equals target index
    logic       after;  // cell index is above target index
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hdl/opl_cell.sv]
`default_nettype none

module opl_cell #(
  parameter int unsigned PID_BITS = 8
) (
  input  wire logic                  clk,
  input  wire opl_pkg::cell_ctrl_t   ctrl,
  input  wire logic [PID_BITS-1:0]   new_pid,
  input  wire logic [PID_BITS-1:0]   left_q,
  input  wire logic [PID_BITS-1:0]   right_q,
  output logic      [PID_BITS-1:0]   q,
  output logic      [PID_BITS-1:0]   rd
);
  import opl_pkg::*;

  logic [PID_BITS-1:0] entry_r;
  logic [PID_BITS-1:0] entry_nxt;

  // insert: target loads the new pid, cells above take from below
  // remove: target and cells above take from the neighbor above
  always_comb begin
    entry_nxt = entry_r;
    case (ctrl.op)
      CELL_INSERT: begin
        if (ctrl.at) begin
          entry_nxt = new_pid;
        end else if (ctrl.after) begin
          entry_nxt = left_q;
        end
      end
      CELL_REMOVE: begin
        if (ctrl.at || ctrl.after) begin
          entry_nxt = right_q;
        end
      end
      default: begin
        entry_nxt = entry_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign q  = entry_r;
  // only the target cell drives its value onto the read bus
  assign rd = ctrl.at ? entry_r : '0;

endmodule

`default_nettype wire

[hdl/ordered_pid_list.sv]
// ordered_pid_list: bounded ordered list of process ids (scheduler ready queue).
// Request channel (in_valid/in_ready): in_kind selects append at tail, insert
// at a one-based clamped in_position, remove head, or remove at zero-based
// in_position. in_pid is the id to store; it is ignored for removals.
// Result channel (out_valid/out_ready): one result per request with
// out_status (ok, full, or missing: empty list or bad index), out_pid_out (removed id,
// zero otherwise) and out_count (entries after the request).
// The result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle while the result is taken. Every entry
// lives in its own cell of a shifting row, so each insert or removal shifts
// the row in place. A stalled receiver holds the result register; in_ready stays
// high as long as the result register is empty or being taken in the same cycle.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// result; stored ids are not cleared and are never read before written.
`default_nettype none

module ordered_pid_list #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned PID_BITS = 8,
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1)
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [opl_pkg::KIND_W-1:0]      in_kind,
  input  wire logic [opl_pkg::PID_W-1:0]       in_pid,
  input  wire logic [opl_pkg::POS_W-1:0]       in_position,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [opl_pkg::STATUS_W-1:0]    out_status,
  output logic      [opl_pkg::PID_W-1:0]       out_pid_out,
  output logic      [CNT_W-1:0]                out_count
);
  import opl_pkg::*;

  // common width for index math over position and count
  localparam int unsigned IW = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0]    used_r;
  logic [CNT_W-1:0]    used_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [STATUS_W-1:0] out_status_nxt;
  logic [PID_W-1:0]    out_pid_r;
  logic [PID_W-1:0]    out_pid_nxt;
  logic [CNT_W-1:0]    out_count_r;
  logic [CNT_W-1:0]    out_count_nxt;

  logic          in_fire;
  kind_e_t       kind;
  logic [IW-1:0] pos_w;
  logic [IW-1:0] used_w;
  logic [IW-1:0] ins_pos;
  logic [IW-1:0] tgt;
  logic          is_ins;
  logic          is_full;
  logic          is_missing;
  cell_op_e_t    op;

  logic [PID_BITS-1:0] new_pid;
  logic [PID_BITS-1:0] cell_q  [DEPTH];
  logic [PID_BITS-1:0] cell_rd [DEPTH];
  logic [PID_BITS-1:0] rd_pid;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;
  assign kind     = kind_e_t'(in_kind);
  assign pos_w    = IW'(in_position);
  assign used_w   = IW'(used_r);
  assign new_pid  = PID_BITS'(in_pid);

  // target index and success checks
  always_comb begin
    ins_pos    = (pos_w <= IW'(1)) ? '0 : pos_w - IW'(1);
    tgt        = '0;
    is_ins     = 1'b0;
    is_missing = 1'b0;
    case (kind)
      KIND_APPEND: begin
        is_ins = 1'b1;
        tgt    = used_w;
      end
      KIND_INSERT: begin
        is_ins = 1'b1;
        tgt    = (ins_pos > used_w) ? used_w : ins_pos;
      end
      KIND_POP: begin
        tgt        = '0;
        is_missing = (used_r == '0);
      end
      KIND_REMOVE: begin
        tgt        = pos_w;
        is_missing = (pos_w >= used_w);
      end
      default: begin
        tgt = '0;
      end
    endcase
    is_full = is_ins && (used_r == CNT_W'(DEPTH));
  end

  // operation broadcast to the row; nothing moves on a refused request
  always_comb begin
    op = CELL_HOLD;
    if (in_fire && !is_full && !is_missing) begin
      op = is_ins ? CELL_INSERT : CELL_REMOVE;
    end
  end

  // row of cells, each linked to its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_ctrl_t          ctrl;
    logic [PID_BITS-1:0] left_q;
    logic [PID_BITS-1:0] right_q;

    assign ctrl.op    = op;
    assign ctrl.at    = (tgt == IW'(i));
    assign ctrl.after = (tgt < IW'(i));

    if (i == 0) begin : g_first
      assign left_q = '0;
    end else begin : g_left
      assign left_q = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_right
      assign right_q = cell_q[i+1];
    end

    opl_cell #(
      .PID_BITS (PID_BITS)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .new_pid (new_pid),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[i]),
      .rd      (cell_rd[i])
    );
  end

  // read bus: only the target cell contributes
  always_comb begin
    rd_pid = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_pid = rd_pid | cell_rd[i];
    end
  end

  // count and result register next values
  always_comb begin
    used_nxt       = used_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_pid_nxt    = out_pid_r;
    out_count_nxt  = out_count_r;
    case (op)
      CELL_INSERT: used_nxt = used_r + CNT_W'(1);
      CELL_REMOVE: used_nxt = used_r - CNT_W'(1);
      default:     used_nxt = used_r;
    endcase
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_count_nxt = used_nxt;
      if (is_full) begin
        out_status_nxt = ST_FULL;
        out_pid_nxt    = '0;
      end else if (is_missing) begin
        out_status_nxt = ST_MISSING;
        out_pid_nxt    = '0;
      end else begin
        out_status_nxt = ST_OK;
        out_pid_nxt    = is_ins ? '0 : PID_W'(rd_pid);
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_pid_r    <= out_pid_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_pid_out = out_pid_r;
  assign out_count   = out_count_r;

  // count never passes the capacity
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

  // a refused request carries no pid
  a_fail_no_pid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> (out_pid_r == '0))
    else $error("failed request returned a pid");

  // full is reported only at capacity
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_FULL) |-> (out_count_r == CNT_W'(DEPTH)))
    else $error("full status below capacity");

  // every accepted request yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted request produced no result");

  // count holds when no request is taken
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(used_r))
    else $error("count changed without a request");

endmodule

`default_nettype wire
